FILE: design/uhr_pkg.sv
// Shared types, constants and saturating arithmetic for the unit hydrograph router.
// Used by uhr_tap_engine and unit_hydrograph_routing_core; depends on nothing else.
`default_nettype none

package uhr_pkg;

   // Default sizes, handed down as module parameters.
   localparam int CELLS_DEF  = 4096;
   localparam int TAPS_DEF   = 32;
   localparam int BASINS_DEF = 64;

   // Fixed datapath widths.
   localparam int FLOW_W   = 48;
   localparam int PROD_W   = 52;
   localparam int WGT_W    = 16;
   localparam int INFLOW_W = 44;
   localparam int FRAC_SH  = 24;
   localparam int CELL_W   = 16;
   localparam int TAPI_W   = 8;
   localparam int WIN_W    = 5;
   localparam int CMP_W    = 9;

   localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

   // Step request from the sequencer to the tap engine.
   typedef struct packed {
      logic              start;
      logic [CELL_W-1:0] cell_num;
      logic [WIN_W-1:0]  win_start;
      logic [WIN_W-1:0]  win_end;
      logic [PROD_W-1:0] product;
   } eng_cmd_type;

   // Weight load into the tap engine's weight memory.
   typedef struct packed {
      logic              en;
      logic [CELL_W-1:0] cell_num;
      logic [TAPI_W-1:0] tap;
      logic [WGT_W-1:0]  data;
   } wgt_wr_type;

   // Status of the tap engine.
   typedef struct packed {
      logic              ready;
      logic              busy;
      logic              done;
      logic [FLOW_W-1:0] tap0;
   } eng_sts_type;

   // Add two flows, saturating at the largest flow value.
   function automatic logic [FLOW_W-1:0] sat_add(input logic [FLOW_W-1:0] a,
                                                 input logic [FLOW_W-1:0] b);
      logic [FLOW_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[FLOW_W] ? FLOW_MAX : s[FLOW_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: design/uhr_tap_engine.sv
// Tap engine: per-cell delay line and weight memories with one shared multiplier.
// Depends on uhr_pkg for the request, weight and status structs and sat_add.
`default_nettype none

module uhr_tap_engine #(
   parameter int CELLS = uhr_pkg::CELLS_DEF,
   parameter int TAPS  = uhr_pkg::TAPS_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  uhr_pkg::eng_cmd_type eng_cmd,
   input  uhr_pkg::wgt_wr_type  wgt_wr,
   output uhr_pkg::eng_sts_type eng_sts
);

   localparam int DEPTH = CELLS * TAPS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int TW    = $clog2(TAPS);
   localparam int MUL_W = uhr_pkg::PROD_W + uhr_pkg::WGT_W;
   localparam logic [AW-1:0] TAPS_A   = AW'(TAPS);
   localparam logic [AW-1:0] DEPTH_LAST = AW'(DEPTH - 1);
   localparam logic [TW-1:0] TAP_LAST = TW'(TAPS - 1);

   typedef enum logic [1:0] {E_CLEAR, E_IDLE, E_RUN, E_WAIT} eng_state_type;

   eng_state_type                   state_ff;
   logic [AW-1:0]                   clr_ff;
   logic [TW-1:0]                   k_ff;
   logic [AW-1:0]                   base_ff;
   logic [uhr_pkg::WIN_W-1:0]       ws_ff;
   logic [uhr_pkg::WIN_W-1:0]       we_ff;
   logic [uhr_pkg::PROD_W-1:0]      prod_ff;

   // Memories and their registered read data.
   logic [uhr_pkg::FLOW_W-1:0]      dly_mem [DEPTH];
   logic [uhr_pkg::WGT_W-1:0]       wgt_mem [DEPTH];
   logic [uhr_pkg::FLOW_W-1:0]      dly_rd_ff;
   logic [uhr_pkg::WGT_W-1:0]       wgt_rd_ff;

   // Pipeline stage registers.
   logic                            s1_valid_ff, s1_top_ff, s1_win_ff, s1_first_ff, s1_last_ff;
   logic [AW-1:0]                   s1_waddr_ff;
   logic                            s2_valid_ff, s2_win_ff, s2_first_ff, s2_last_ff;
   logic [AW-1:0]                   s2_waddr_ff;
   logic [uhr_pkg::FLOW_W-1:0]      old_ff;
   logic [uhr_pkg::INFLOW_W-1:0]    inflow_ff;
   logic [uhr_pkg::FLOW_W-1:0]      tap0_ff;

   logic                            issue;
   logic                            clearing;
   logic [AW-1:0]                   rd_addr;
   logic [AW-1:0]                   w_addr;
   logic                            in_win;
   logic [uhr_pkg::CMP_W-1:0]       k_x;
   logic [AW-1:0]                   wgt_waddr;
   logic [MUL_W-1:0]                mul;
   logic [uhr_pkg::FLOW_W-1:0]      add_val;
   logic [uhr_pkg::FLOW_W-1:0]      sum;
   logic                            dly_we;
   logic [AW-1:0]                   dly_waddr;
   logic [uhr_pkg::FLOW_W-1:0]      dly_wdata;

   // Read addresses for the tap being issued: delay entry k+1, weight entry k.
   assign issue    = (state_ff == E_RUN);
   assign clearing = (state_ff == E_CLEAR);
   assign w_addr   = base_ff + AW'(k_ff);
   assign rd_addr  = (k_ff == TAP_LAST) ? base_ff : (w_addr + AW'(1));
   assign k_x      = uhr_pkg::CMP_W'(k_ff);
   assign in_win   = (k_x >= uhr_pkg::CMP_W'(ws_ff)) && (k_x <= uhr_pkg::CMP_W'(we_ff));
   assign wgt_waddr = AW'(wgt_wr.cell_num[CW-1:0]) * TAPS_A + AW'(wgt_wr.tap[TW-1:0]);

   // Shared multiplier and saturating add.
   assign mul     = MUL_W'(prod_ff) * MUL_W'(wgt_rd_ff);
   assign add_val = s2_win_ff ? uhr_pkg::FLOW_W'(inflow_ff) : '0;
   assign sum     = uhr_pkg::sat_add(old_ff, add_val);

   assign dly_we    = clearing || s2_valid_ff;
   assign dly_waddr = clearing ? clr_ff : s2_waddr_ff;
   assign dly_wdata = clearing ? '0 : sum;

   // Sequencer: clearing pass after reset, then one tap issued per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_CLEAR;
         clr_ff   <= '0;
         k_ff     <= '0;
      end else begin
         unique case (state_ff)
            E_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == DEPTH_LAST) begin
                  state_ff <= E_IDLE;
               end
            end
            E_IDLE: begin
               if (eng_cmd.start) begin
                  k_ff     <= '0;
                  state_ff <= E_RUN;
               end
            end
            E_RUN: begin
               k_ff <= k_ff + TW'(1);
               if (k_ff == TAP_LAST) begin
                  state_ff <= E_WAIT;
               end
            end
            E_WAIT: begin
               if (s2_valid_ff && s2_last_ff) begin
                  state_ff <= E_IDLE;
               end
            end
            default: state_ff <= E_CLEAR;
         endcase
      end
   end

   // Step parameters latched at start.
   always_ff @(posedge clock) begin
      if (state_ff == E_IDLE && eng_cmd.start) begin
         base_ff <= AW'(eng_cmd.cell_num[CW-1:0]) * TAPS_A;
         ws_ff   <= eng_cmd.win_start;
         we_ff   <= eng_cmd.win_end;
         prod_ff <= eng_cmd.product;
      end
   end

   // Delay line memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[dly_waddr] <= dly_wdata;
      end
      dly_rd_ff <= dly_mem[rd_addr];
   end

   // Weight memory: written by load items, read by the tap walk.
   always_ff @(posedge clock) begin
      if (wgt_wr.en) begin
         wgt_mem[wgt_waddr] <= wgt_wr.data;
      end
      wgt_rd_ff <= wgt_mem[w_addr];
   end

   // Pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Pipeline payload: the top tap reads as zero after the shift.
   always_ff @(posedge clock) begin
      s1_top_ff   <= (k_ff == TAP_LAST);
      s1_win_ff   <= in_win;
      s1_first_ff <= (k_ff == '0);
      s1_last_ff  <= (k_ff == TAP_LAST);
      s1_waddr_ff <= w_addr;
      s2_win_ff   <= s1_win_ff;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_waddr_ff <= s1_waddr_ff;
      old_ff      <= s1_top_ff ? '0 : dly_rd_ff;
      inflow_ff   <= mul[uhr_pkg::FRAC_SH +: uhr_pkg::INFLOW_W];
      if (s2_valid_ff && s2_first_ff) begin
         tap0_ff <= sum;
      end
   end

   assign eng_sts.ready = (state_ff != E_CLEAR);
   assign eng_sts.busy  = (state_ff == E_RUN) || (state_ff == E_WAIT);
   assign eng_sts.done  = s2_valid_ff && s2_last_ff;
   assign eng_sts.tap0  = tap0_ff;

endmodule

`default_nettype wire

FILE: design/unit_hydrograph_routing_core.sv
// Top level of the unit hydrograph router: sequencer, cell descriptors, subbasin totals.
// Depends on uhr_pkg and instantiates uhr_tap_engine.
`default_nettype none

// A load item is written as it is accepted, and the block stays ready. A step item
// has the tap engine walk the cell's delay line one entry per cycle through its single
// multiplier, then the subbasin total is read and updated (skipped when the cell names
// an invalid subbasin). A close item can be held by a stalling result side: the totals
// are read once to form the watershed sum, once to send them, and all BASINS entries
// are then cleared. After reset the block runs a clearing pass over the delay line
// memory before it takes its first item; configuration writes are taken at any time.
module unit_hydrograph_routing_core #(
   parameter int CELLS  = uhr_pkg::CELLS_DEF,
   parameter int TAPS   = uhr_pkg::TAPS_DEF,
   parameter int BASINS = uhr_pkg::BASINS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_cmd,
   input  wire  [11:0] req_cell_req,
   input  wire  [4:0]  req_tap,
   input  wire  [15:0] req_weight,
   input  wire  [4:0]  req_window_start,
   input  wire  [4:0]  req_window_end,
   input  wire  [5:0]  req_basin_id,
   input  wire  [19:0] req_runoff,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [5:0]  rsp_basin_index,
   output logic [47:0] rsp_flow,
   output logic        rsp_last,
   output logic        rsp_error,
   input  wire         csr_we,
   input  wire  [0:0]  csr_index,
   input  wire  [31:0] csr_wdata
);

   localparam int CW = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int BW = $clog2(BASINS);
   localparam logic [BW-1:0] BASIN_LAST = BW'(BASINS - 1);
   localparam logic [5:0]    N_MAX      = 6'(BASINS - 1);

   localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
   localparam logic [1:0] CMD_LOAD_CELL   = 2'd1;
   localparam logic [1:0] CMD_STEP        = 2'd2;
   localparam logic [1:0] CMD_CLOSE       = 2'd3;

   localparam logic [0:0] REG_FLOW_SCALE     = 1'b0;
   localparam logic [0:0] REG_SUBBASIN_COUNT = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DESC, ST_RUN, ST_BRD, ST_BACC,
      ST_SUM_RD, ST_SUM_ACC, ST_EMIT0, ST_EM_RD, ST_EM_LD
   } state_type;

   state_type                  state_ff;
   logic [31:0]                flow_scale_ff;
   logic [5:0]                 count_ff;
   logic                       err_ff;
   logic [BW-1:0]              clr_ff;
   logic [5:0]                 n_ff;
   logic [5:0]                 b_ff;
   logic [5:0]                 id_ff;
   logic [uhr_pkg::FLOW_W-1:0] total_ff;
   logic [uhr_pkg::PROD_W-1:0] p_ff;
   logic [15:0]                cell_ff;

   logic [15:0]                desc_mem [CELLS];
   logic [15:0]                desc_rd_ff;
   logic [uhr_pkg::FLOW_W-1:0] basin_mem [BASINS];
   logic [uhr_pkg::FLOW_W-1:0] basin_rd_ff;

   logic                       rsp_valid_ff;
   logic [5:0]                 rsp_basin_index_ff;
   logic [uhr_pkg::FLOW_W-1:0] rsp_flow_ff;
   logic                       rsp_last_ff;
   logic                       rsp_error_ff;

   logic                       accept;
   logic                       out_free;
   logic                       rsp_load;
   logic [16:0]                cell_x;
   logic                       cell_ok;
   logic [CW-1:0]              cell_idx;
   logic [8:0]                 tap_x;
   logic                       tap_ok;
   logic [5:0]                 n_in;
   logic [5:0]                 id_in;
   logic                       bad_in;
   logic [BW-1:0]              basin_raddr;
   logic                       basin_we;
   logic [BW-1:0]              basin_waddr;
   logic [uhr_pkg::FLOW_W-1:0] basin_wdata;

   uhr_pkg::eng_cmd_type       eng_cmd;
   uhr_pkg::wgt_wr_type        wgt_wr;
   uhr_pkg::eng_sts_type       eng_sts;

   // Input decode.
   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = out_free && ((state_ff == ST_EMIT0) || (state_ff == ST_EM_LD));
   assign cell_x   = 17'(req_cell_req);
   assign cell_ok  = (cell_x < 17'(CELLS));
   assign cell_idx = cell_x[CW-1:0];
   assign tap_x    = 9'(req_tap);
   assign tap_ok   = (tap_x < 9'(TAPS));
   assign n_in     = (count_ff > N_MAX) ? N_MAX : count_ff;

   // Subbasin of the stepped cell; a single subbasin takes every cell.
   assign id_in  = (count_ff == 6'd1) ? 6'd1 : desc_rd_ff[15:10];
   assign bad_in = (id_in > count_ff) || (7'(id_in) >= 7'(BASINS));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         flow_scale_ff <= 32'd65536;
         count_ff      <= 6'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_FLOW_SCALE:     flow_scale_ff <= csr_wdata;
            REG_SUBBASIN_COUNT: count_ff      <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // Cell descriptor memory: {basin, window end, window start}.
   always_ff @(posedge clock) begin
      if (accept && req_cmd == CMD_LOAD_CELL && cell_ok) begin
         desc_mem[cell_idx] <= {req_basin_id, req_window_end, req_window_start};
      end
      if (accept) begin
         desc_rd_ff <= desc_mem[cell_idx];
      end
   end

   // Step operands captured at accept: runoff times scale is formed here.
   always_ff @(posedge clock) begin
      if (accept) begin
         p_ff    <= uhr_pkg::PROD_W'(req_runoff) * uhr_pkg::PROD_W'(flow_scale_ff);
         cell_ff <= 16'(cell_idx);
      end
   end

   // Weight loads go straight to the tap engine.
   assign wgt_wr.en       = accept && (req_cmd == CMD_LOAD_WEIGHT) && cell_ok && tap_ok;
   assign wgt_wr.cell_num = 16'(cell_idx);
   assign wgt_wr.tap      = tap_x[7:0];
   assign wgt_wr.data     = req_weight;

   assign eng_cmd.start     = (state_ff == ST_DESC);
   assign eng_cmd.cell_num  = cell_ff;
   assign eng_cmd.win_start = desc_rd_ff[4:0];
   assign eng_cmd.win_end   = desc_rd_ff[9:5];
   assign eng_cmd.product   = p_ff;

   uhr_tap_engine #(
      .CELLS (CELLS),
      .TAPS  (TAPS)
   ) u_tap_engine (
      .clock   (clock),
      .reset   (reset),
      .eng_cmd (eng_cmd),
      .wgt_wr  (wgt_wr),
      .eng_sts (eng_sts)
   );

   // Subbasin total memory access.
   always_comb begin
      case (state_ff)
         ST_BRD, ST_BACC: basin_raddr = id_ff[BW-1:0];
         default:         basin_raddr = b_ff[BW-1:0];
      endcase
      basin_we    = 1'b0;
      basin_waddr = clr_ff;
      basin_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         basin_we = 1'b1;
      end else if (state_ff == ST_BACC) begin
         basin_we    = 1'b1;
         basin_waddr = id_ff[BW-1:0];
         basin_wdata = uhr_pkg::sat_add(basin_rd_ff, eng_sts.tap0);
      end
   end

   always_ff @(posedge clock) begin
      if (basin_we) begin
         basin_mem[basin_waddr] <= basin_wdata;
      end
      basin_rd_ff <= basin_mem[basin_raddr];
   end

   // Sequencer with the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (clr_ff != BASIN_LAST) begin
                  clr_ff <= clr_ff + BW'(1);
               end else if (eng_sts.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  if (req_cmd == CMD_CLOSE) begin
                     n_ff     <= n_in;
                     b_ff     <= 6'd1;
                     total_ff <= '0;
                     state_ff <= (n_in == 6'd0) ? ST_EMIT0 : ST_SUM_RD;
                  end else if (req_cmd == CMD_STEP && cell_ok) begin
                     state_ff <= ST_DESC;
                  end
               end
            end
            ST_DESC: state_ff <= ST_RUN;
            ST_RUN: begin
               if (eng_sts.done) begin
                  if (bad_in) begin
                     err_ff   <= 1'b1;
                     state_ff <= ST_IDLE;
                  end else begin
                     id_ff    <= id_in;
                     state_ff <= ST_BRD;
                  end
               end
            end
            ST_BRD:  state_ff <= ST_BACC;
            ST_BACC: state_ff <= ST_IDLE;
            ST_SUM_RD: state_ff <= ST_SUM_ACC;
            ST_SUM_ACC: begin
               total_ff <= uhr_pkg::sat_add(total_ff, basin_rd_ff);
               if (b_ff == n_ff) begin
                  b_ff     <= 6'd1;
                  state_ff <= ST_EMIT0;
               end else begin
                  b_ff     <= b_ff + 6'd1;
                  state_ff <= ST_SUM_RD;
               end
            end
            ST_EMIT0: begin
               if (out_free) begin
                  rsp_basin_index_ff <= 6'd0;
                  rsp_flow_ff        <= total_ff;
                  rsp_last_ff        <= (n_ff == 6'd0);
                  rsp_error_ff       <= err_ff;
                  b_ff               <= 6'd1;
                  clr_ff             <= '0;
                  state_ff           <= (n_ff == 6'd0) ? ST_CLEAR : ST_EM_RD;
               end
            end
            ST_EM_RD: state_ff <= ST_EM_LD;
            ST_EM_LD: begin
               if (out_free) begin
                  rsp_basin_index_ff <= b_ff;
                  rsp_flow_ff        <= basin_rd_ff;
                  rsp_last_ff        <= (b_ff == n_ff);
                  rsp_error_ff       <= err_ff;
                  if (b_ff == n_ff) begin
                     clr_ff   <= '0;
                     state_ff <= ST_CLEAR;
                  end else begin
                     b_ff     <= b_ff + 6'd1;
                     state_ff <= ST_EM_RD;
                  end
               end
            end
            default: state_ff <= ST_CLEAR;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_basin_index = rsp_basin_index_ff;
   assign rsp_flow        = rsp_flow_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_error       = rsp_error_ff;

`ifndef NO_ASSERTIONS
   // The tap engine is never busy while the block takes items.
   a_idle_engine_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !eng_sts.busy)
      else $error("tap engine busy while idle");

   // A finished tap walk only arrives while the sequencer waits for it.
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      eng_sts.done |-> (state_ff == ST_RUN))
      else $error("tap walk finished outside the run state");

   // The bad subbasin flag stays set until reset.
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff |=> err_ff)
      else $error("error flag cleared without reset");

   // A step starts the tap engine only when it is free.
   a_start_free: assert property (@(posedge clock) disable iff (reset)
      eng_cmd.start |-> (eng_sts.ready && !eng_sts.busy))
      else $error("tap engine started while not free");
`endif

endmodule

`default_nettype wire

FILE: test/uhr_route_checker.sv
// Checker for the unit hydrograph router: mirrors the routing state and compares results.
// Depends on uhr_pkg for the flow width; watches the request and result channels.
`timescale 1ns / 100ps

module uhr_route_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   input  wire         req_stall,
   input  wire  [1:0]  req_cmd,
   input  wire  [11:0] req_cell_req,
   input  wire  [4:0]  req_tap,
   input  wire  [15:0] req_weight,
   input  wire  [4:0]  req_window_start,
   input  wire  [4:0]  req_window_end,
   input  wire  [5:0]  req_basin_id,
   input  wire  [19:0] req_runoff,
   input  wire         rsp_valid,
   input  wire         rsp_stall,
   input  wire  [5:0]  rsp_basin_index,
   input  wire  [47:0] rsp_flow,
   input  wire         rsp_last,
   input  wire         rsp_error,
   input  wire         csr_we,
   input  wire  [0:0]  csr_index,
   input  wire  [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);

   localparam int FW    = uhr_pkg::FLOW_W;
   localparam int NTAP  = 32;
   localparam int NBAS  = 64;
   localparam logic [1:0] CMD_WEIGHT = 2'd0;
   localparam logic [1:0] CMD_DESC   = 2'd1;
   localparam logic [1:0] CMD_STEP   = 2'd2;
   localparam logic [1:0] CMD_CLOSE  = 2'd3;
   localparam logic [0:0] REG_SCALE  = 1'b0;
   localparam logic [0:0] REG_COUNT  = 1'b1;

   typedef struct packed {
      logic [5:0]    index;
      logic [FW-1:0] flow;
      logic          last;
      logic          error;
   } basin_report_type;

   // Mirror of the block's state; only a few cells are used, so associative arrays.
   logic [FW-1:0]     line_mem [int][NTAP];
   logic [15:0]       wgt_mem  [int][NTAP];
   logic [4:0]        win_lo   [int];
   logic [4:0]        win_hi   [int];
   logic [5:0]        cell_bas [int];
   logic [FW-1:0]     totals   [NBAS];
   logic              bad_seen;
   logic [31:0]       scale;
   logic [5:0]        count;
   basin_report_type  expected_reports [$];

   function automatic logic [FW-1:0] add_sat(logic [FW-1:0] a, logic [FW-1:0] b);
      logic [FW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[FW] ? {FW{1'b1}} : s[FW-1:0];
   endfunction

   // floor(runoff * scale * weight / 2^24), exact in wide arithmetic.
   function automatic logic [FW-1:0] inflow(logic [19:0] r, logic [15:0] w);
      logic [83:0] p;
      p = (84'(r) * 84'(scale) * 84'(w)) >> 24;
      return p[FW-1:0];
   endfunction

   task automatic route_item();
      int c;
      int n;
      logic [FW-1:0] sum;
      logic [5:0] id;
      basin_report_type r;
      c = req_cell_req;
      case (req_cmd)
         CMD_CLOSE: begin
            n = (count > NBAS - 1) ? NBAS - 1 : count;
            sum = '0;
            for (int b = 1; b <= n; b++) sum = add_sat(sum, totals[b]);
            r = '{6'd0, sum, n == 0, bad_seen};
            expected_reports.push_back(r);
            for (int b = 1; b <= n; b++) begin
               r = '{6'(b), totals[b], b == n, bad_seen};
               expected_reports.push_back(r);
            end
            for (int b = 0; b < NBAS; b++) totals[b] = '0;
         end
         CMD_WEIGHT: begin
            if (!wgt_mem.exists(c))
               for (int k = 0; k < NTAP; k++) wgt_mem[c][k] = '0;
            wgt_mem[c][req_tap] = req_weight;
         end
         CMD_DESC: begin
            win_lo[c] = req_window_start;
            win_hi[c] = req_window_end;
            cell_bas[c] = req_basin_id;
         end
         CMD_STEP: begin
            if (!line_mem.exists(c))
               for (int k = 0; k < NTAP; k++) line_mem[c][k] = '0;
            if (!wgt_mem.exists(c))
               for (int k = 0; k < NTAP; k++) wgt_mem[c][k] = '0;
            for (int k = 0; k < NTAP - 1; k++) line_mem[c][k] = line_mem[c][k+1];
            line_mem[c][NTAP-1] = '0;
            if (win_lo.exists(c))
               for (int k = win_lo[c]; k <= win_hi[c]; k++)
                  line_mem[c][k] = add_sat(line_mem[c][k], inflow(req_runoff, wgt_mem[c][k]));
            id = (count == 1) ? 6'd1 : (cell_bas.exists(c) ? cell_bas[c] : 6'd0);
            if (id > count || id >= NBAS) bad_seen = 1'b1;
            else totals[id] = add_sat(totals[id], line_mem[c][0]);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      basin_report_type want;
      if (reset) begin
         line_mem.delete();
         wgt_mem.delete();
         win_lo.delete();
         win_hi.delete();
         cell_bas.delete();
         for (int b = 0; b < NBAS; b++) totals[b] = '0;
         bad_seen = 1'b0;
         scale = 32'd65536;
         count = 6'd1;
         expected_reports.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_SCALE) scale = csr_wdata;
            else if (csr_index == REG_COUNT) count = csr_wdata[5:0];
         end
         if (req_valid && !req_stall) route_item();
         // Compare each delivered result with the oldest expected one.
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               if (fail_count < 10) $display("unexpected result index %0d", rsp_basin_index);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_reports.pop_front();
               if (want != {rsp_basin_index, rsp_flow, rsp_last, rsp_error}) begin
                  if (fail_count < 10)
                     $display({"mismatch: expected idx %0d flow %0h last %0b err %0b, ",
                               "got %0d %0h %0b %0b"},
                              want.index, want.flow, want.last, want.error,
                              rsp_basin_index, rsp_flow, rsp_last, rsp_error);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= expected_reports.size();
   end
endmodule

FILE: test/tb_unit_hydrograph_routing_core.sv
// Top of the unit hydrograph router testbench: clock, reset, stimulus and verdict.
// Depends on uhr_pkg, unit_hydrograph_routing_core and uhr_route_checker.
`timescale 1ns / 100ps

module tb_unit_hydrograph_routing_core;
   localparam logic [1:0] CMD_WEIGHT = 2'd0;
   localparam logic [1:0] CMD_DESC   = 2'd1;
   localparam logic [1:0] CMD_STEP   = 2'd2;
   localparam logic [1:0] CMD_CLOSE  = 2'd3;
   localparam logic [0:0] REG_SCALE  = 1'b0;
   localparam logic [0:0] REG_COUNT  = 1'b1;
   localparam int NCELL = 4096;
   localparam longint CYCLE_LIMIT = 64'd4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [1:0] req_cmd = '0;
   logic [11:0] req_cell_req = '0;
   logic [4:0] req_tap = '0;
   logic [15:0] req_weight = '0;
   logic [4:0] req_window_start = '0;
   logic [4:0] req_window_end = '0;
   logic [5:0] req_basin_id = '0;
   logic [19:0] req_runoff = '0;
   logic rsp_stall = 1'b0;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   wire req_stall, rsp_valid, rsp_last, rsp_error;
   wire [5:0] rsp_basin_index;
   wire [47:0] rsp_flow;
   int fail_count, pending_count;
   longint cycles = 0;
   logic [11:0] active_cells [2];

   unit_hydrograph_routing_core dut (.*);
   uhr_route_checker checker_i (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Result-side stall: a random number of stalled cycles before each result.
   initial begin
      int wait_n;
      forever begin
         wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         repeat (wait_n) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_unit_hydrograph_routing_core failed");
         $finish;
      end
   end

   // Valid stays high after acceptance only when the next item follows at once.
   task automatic send_item(logic [1:0] c, logic [11:0] cell_num, logic [4:0] tp,
                            logic [15:0] w, logic [4:0] ws, logic [4:0] we, logic [5:0] b,
                            logic [19:0] r);
      int gap;
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_cell_req <= cell_num;
      req_tap <= tp;
      req_weight <= w;
      req_window_start <= ws;
      req_window_end <= we;
      req_basin_id <= b;
      req_runoff <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // An item with random payload for the given command and cell.
   task automatic send_random(logic [1:0] c, logic [11:0] cell_num);
      send_item(c, cell_num, 5'($urandom), 16'($urandom), 5'($urandom), 5'($urandom),
                6'($urandom), 20'($urandom));
   endtask

   task automatic write_reg(logic [0:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Stop sending, then wait until all results are in and the block is idle again.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || req_stall) @(posedge clock);
   endtask

   // Load a full descriptor and weight set for a cell.
   task automatic load_cell(logic [11:0] cell_num, logic [5:0] b);
      send_item(CMD_DESC, cell_num, 5'($urandom), 16'($urandom), 5'($urandom_range(0, 31)),
                5'($urandom_range(0, 31)), b, 20'($urandom));
      for (int k = 0; k < 32; k++)
         send_item(CMD_WEIGHT, cell_num, 5'(k), 16'($urandom), 5'($urandom), 5'($urandom),
                   6'($urandom), 20'($urandom));
   endtask

   initial begin
      int count_set;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of cells, weights, runoff and windows.
      send_item(CMD_DESC, 12'd0, 5'd0, 16'd0, 5'd0, 5'd31, 6'd1, 20'd0);
      send_item(CMD_DESC, 12'd4095, 5'd31, 16'hFFFF, 5'd20, 5'd3, 6'd63, 20'hFFFFF);
      for (int k = 0; k < 32; k++) begin
         send_item(CMD_WEIGHT, 12'd0, 5'(k), 16'hFFFF, 5'd0, 5'd0, 6'd0, 20'd0);
         send_item(CMD_WEIGHT, 12'd4095, 5'(k), 16'd0, 5'd31, 5'd31, 6'd63, 20'hFFFFF);
      end
      send_item(CMD_STEP, 12'd0, 5'd0, 16'd0, 5'd0, 5'd0, 6'd0, 20'hFFFFF);
      send_item(CMD_STEP, 12'd4095, 5'd31, 16'hFFFF, 5'd31, 5'd31, 6'd63, 20'd0);
      send_item(CMD_CLOSE, 12'd0, 5'd0, 16'd0, 5'd0, 5'd0, 6'd0, 20'd0);
      drain();
      // Saturation: largest scale on the full window.
      write_reg(REG_SCALE, 32'hFFFFFFFF);
      write_reg(REG_COUNT, 32'd63);
      for (int i = 0; i < 6; i++)
         send_item(CMD_STEP, 12'd0, 5'd0, 16'd0, 5'd0, 5'd0, 6'd0, 20'hFFFFF);
      send_item(CMD_STEP, 12'd4095, 5'd0, 16'd0, 5'd0, 5'd0, 6'd0, 20'h1);
      send_item(CMD_CLOSE, 12'hFFF, 5'h1F, 16'hFFFF, 5'h1F, 5'h1F, 6'h3F, 20'hFFFFF);
      drain();
      // Zero count, then a subbasin above the count for the sticky error.
      write_reg(REG_COUNT, 32'd0);
      send_item(CMD_CLOSE, 12'd0, 5'd0, 16'd0, 5'd0, 5'd0, 6'd0, 20'd0);
      drain();
      write_reg(REG_COUNT, 32'd2);
      write_reg(REG_SCALE, 32'd0);
      send_item(CMD_STEP, 12'd4095, 5'd0, 16'd0, 5'd0, 5'd0, 6'd0, 20'd5);
      send_item(CMD_CLOSE, 12'd0, 5'd0, 16'd0, 5'd0, 5'd0, 6'd0, 20'd0);
      drain();

      // Random phases over a small set of loaded cells.
      for (int ph = 0; ph < 4; ph++) begin
         count_set = (ph == 0) ? 1 : (ph == 3) ? 63 : int'($urandom_range(1, 12));
         write_reg(REG_COUNT, 32'(count_set));
         write_reg(REG_SCALE, (ph == 2) ? 32'hFFFFFFFF : $urandom_range(1, 32'h40000));
         for (int i = 0; i < 2; i++) begin
            active_cells[i] = (i == 0) ? 12'd4095 : 12'($urandom_range(0, NCELL - 1));
            // Mostly valid subbasins, sometimes zero or out of range.
            load_cell(active_cells[i], ($urandom_range(0, 7) == 0)
                                          ? 6'($urandom_range(0, 63))
                                          : 6'($urandom_range(1, count_set)));
         end
         for (int i = 0; i < 40; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_random(CMD_CLOSE, 12'($urandom));
            else if ($urandom_range(0, 11) == 0)
               send_random(CMD_WEIGHT, active_cells[$urandom_range(0, 1)]);
            else
               send_random(CMD_STEP, active_cells[$urandom_range(0, 1)]);
         end
         send_item(CMD_CLOSE, 12'd0, 5'd0, 16'd0, 5'd0, 5'd0, 6'd0, 20'd0);
         drain();
      end

      if (fail_count == 0 && pending_count == 0)
         $display("tb_unit_hydrograph_routing_core passed");
      else
         $display("tb_unit_hydrograph_routing_core failed");
      $finish;
   end
endmodule
